FILE: hw/rtl/dgrp_pkg.sv
// Shared types and constants for the DLMS GET-Response value parser.
// Used by dgrp_matcher, dgrp_decoder and dlms_get_response_value_parser_top.
package dgrp_pkg;

   // Default number of octets in a clock octet string
   localparam int CLOCK_OCTETS = 12;
   // Clock octets that are kept for the clock result
   localparam int CLOCK_HOLD_DEPTH = 8;

   // Response header bytes
   localparam logic [7:0] GET_RSP_TAG    = 8'hC4;
   localparam logic [7:0] GET_RSP_NORMAL = 8'h01;
   localparam logic [7:0] RESULT_DATA    = 8'h00;
   localparam logic [7:0] RESULT_ERROR   = 8'h01;

   // Data tags
   localparam logic [7:0] TAG_NULL    = 8'h00;
   localparam logic [7:0] TAG_DLU     = 8'h06;
   localparam logic [7:0] TAG_OCTET   = 8'h09;
   localparam logic [7:0] TAG_VISIBLE = 8'h0A;
   localparam logic [7:0] TAG_LU      = 8'h12;

   // Result status codes
   typedef enum logic [2:0] {
      ST_NUMBER      = 3'd0,
      ST_STRING_BYTE = 3'd1,
      ST_CLOCK       = 3'd2,
      ST_NULL        = 3'd3,
      ST_ACCESS_ERR  = 3'd4,
      ST_UNSUPPORTED = 3'd5,
      ST_NO_RESPONSE = 3'd6,
      ST_TRUNCATED   = 3'd7
   } status_type;

   // Parser phases
   typedef enum logic [3:0] {
      PH_SEARCH  = 4'd0,
      PH_ERRCODE = 4'd1,
      PH_TAG     = 4'd2,
      PH_VLEN    = 4'd3,
      PH_OLEN    = 4'd4,
      PH_STRING  = 4'd5,
      PH_CLOCK   = 4'd6,
      PH_NUMBER  = 4'd7,
      PH_DONE    = 4'd8
   } phase_type;

   // Header match found on the current byte
   typedef struct packed {
      logic hit_data;
      logic hit_error;
   } match_type;

   // One result item
   typedef struct packed {
      status_type  status;
      logic [7:0]  error_code;
      logic [7:0]  tag;
      logic [31:0] number_value;
      logic [7:0]  data_byte;
      logic [15:0] year;
      logic [7:0]  month;
      logic [7:0]  day;
      logic [7:0]  hour;
      logic [7:0]  minute;
      logic [7:0]  second;
      logic        end_of_run;
   } rsp_type;

endpackage

FILE: hw/rtl/dgrp_matcher.sv
// Sliding header window: finds C4 01 <invoke id> <result> in the byte stream.
// Depends on dgrp_pkg.
module dgrp_matcher (
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  logic                clear,
   input  logic                searching,
   input  logic [7:0]          in_byte,
   output dgrp_pkg::match_type match
);

   // Last three bytes seen, oldest first, and how many of them are valid
   logic [7:0] window_ff [3];
   logic [7:0] window_in [3];
   logic [1:0] fill_ff;
   logic [1:0] fill_in;
   logic       header_ok;

   // Window full with this byte and header in the two oldest slots
   assign header_ok = (fill_ff == 2'd3) && (window_ff[0] == dgrp_pkg::GET_RSP_TAG)
                      && (window_ff[1] == dgrp_pkg::GET_RSP_NORMAL);
   assign match.hit_data  = header_ok && (in_byte == dgrp_pkg::RESULT_DATA);
   assign match.hit_error = header_ok && (in_byte == dgrp_pkg::RESULT_ERROR);

   // Shift in the new byte
   always_comb begin
      window_in[0] = window_ff[1];
      window_in[1] = window_ff[2];
      window_in[2] = in_byte;
      fill_in      = (fill_ff == 2'd3) ? fill_ff : fill_ff + 2'd1;
   end

   always_ff @(posedge clock) begin
      if (reset || (step && clear)) begin
         fill_ff <= '0;
         for (int i = 0; i < 3; i++) begin
            window_ff[i] <= '0;
         end
      end else if (step && searching) begin
         fill_ff <= fill_in;
         for (int i = 0; i < 3; i++) begin
            window_ff[i] <= window_in[i];
         end
      end
   end

   // A hit needs a full window
   a_hit_needs_fill: assert property (@(posedge clock) disable iff (reset)
      (match.hit_data || match.hit_error) |-> (fill_ff == 2'd3))
      else $error("header hit with window not full");

   // Both hits never at once
   a_hit_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(match.hit_data && match.hit_error))
      else $error("data and error hit together");

   // Frame end empties the window
   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      (step && clear) |=> (fill_ff == 2'd0))
      else $error("window not emptied at frame end");

endmodule

FILE: hw/rtl/dgrp_decoder.sv
// Phase machine and value decode for one accepted byte per step.
// Depends on dgrp_pkg; takes header hits from dgrp_matcher.
module dgrp_decoder #(
   parameter int CLOCK_OCTETS = dgrp_pkg::CLOCK_OCTETS
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  logic [7:0]          in_byte,
   input  logic                frame_end,
   input  dgrp_pkg::match_type match,
   output logic                searching,
   output logic                res_valid,
   output dgrp_pkg::rsp_type   res
);

   localparam logic [7:0] CLOCK_LEN  = 8'(CLOCK_OCTETS);
   localparam logic [3:0] CLOCK_LAST = 4'(CLOCK_OCTETS);
   localparam logic [3:0] HOLD_LAST  = 4'(dgrp_pkg::CLOCK_HOLD_DEPTH);

   dgrp_pkg::phase_type phase_ff, phase_in, phase_step;
   logic [7:0]  held_tag_ff, held_tag_in;
   logic [7:0]  bytes_left_ff, bytes_left_in, bytes_dec;
   logic [3:0]  byte_index_ff, byte_index_in, index_inc;
   logic [31:0] acc_ff, acc_in;
   logic [7:0]  clock_hold_ff [dgrp_pkg::CLOCK_HOLD_DEPTH];
   logic [7:0]  clock_hold_in [dgrp_pkg::CLOCK_HOLD_DEPTH];

   assign searching = (phase_ff == dgrp_pkg::PH_SEARCH);
   assign bytes_dec = bytes_left_ff - 8'd1;
   assign index_inc = byte_index_ff + 4'd1;

   // Next phase and datapath state
   always_comb begin
      phase_step    = phase_ff;
      held_tag_in   = held_tag_ff;
      bytes_left_in = bytes_left_ff;
      byte_index_in = byte_index_ff;
      acc_in        = acc_ff;
      clock_hold_in = clock_hold_ff;
      case (phase_ff)
         dgrp_pkg::PH_SEARCH: begin
            if (match.hit_data) begin
               phase_step = dgrp_pkg::PH_TAG;
            end else if (match.hit_error) begin
               phase_step = dgrp_pkg::PH_ERRCODE;
            end
         end
         dgrp_pkg::PH_ERRCODE: phase_step = dgrp_pkg::PH_DONE;
         dgrp_pkg::PH_TAG: begin
            held_tag_in = in_byte;
            acc_in      = '0;
            case (in_byte)
               dgrp_pkg::TAG_LU: begin
                  bytes_left_in = 8'd2;
                  phase_step    = dgrp_pkg::PH_NUMBER;
               end
               dgrp_pkg::TAG_DLU: begin
                  bytes_left_in = 8'd4;
                  phase_step    = dgrp_pkg::PH_NUMBER;
               end
               dgrp_pkg::TAG_VISIBLE: phase_step = dgrp_pkg::PH_VLEN;
               dgrp_pkg::TAG_OCTET:   phase_step = dgrp_pkg::PH_OLEN;
               default:               phase_step = dgrp_pkg::PH_DONE;
            endcase
         end
         dgrp_pkg::PH_VLEN, dgrp_pkg::PH_OLEN: begin
            if (phase_ff == dgrp_pkg::PH_OLEN && in_byte == CLOCK_LEN) begin
               byte_index_in = '0;
               phase_step    = dgrp_pkg::PH_CLOCK;
            end else if (in_byte == 8'd0) begin
               phase_step = dgrp_pkg::PH_DONE;
            end else begin
               bytes_left_in = in_byte;
               phase_step    = dgrp_pkg::PH_STRING;
            end
         end
         dgrp_pkg::PH_STRING: begin
            bytes_left_in = bytes_dec;
            if (bytes_dec == 8'd0) begin
               phase_step = dgrp_pkg::PH_DONE;
            end
         end
         dgrp_pkg::PH_CLOCK: begin
            if (byte_index_ff < HOLD_LAST) begin
               clock_hold_in[byte_index_ff[2:0]] = in_byte;
            end
            byte_index_in = index_inc;
            if (index_inc >= CLOCK_LAST) begin
               phase_step = dgrp_pkg::PH_DONE;
            end
         end
         dgrp_pkg::PH_NUMBER: begin
            acc_in        = {acc_ff[23:0], in_byte};
            bytes_left_in = bytes_dec;
            if (bytes_dec == 8'd0) begin
               phase_step = dgrp_pkg::PH_DONE;
            end
         end
         default: ;
      endcase
      // Frame end sends the parser back to the search
      phase_in = frame_end ? dgrp_pkg::PH_SEARCH : phase_step;
   end

   // Result of this byte
   always_comb begin
      res       = '0;
      res_valid = 1'b0;
      case (phase_ff)
         dgrp_pkg::PH_ERRCODE: begin
            res_valid      = 1'b1;
            res.status     = dgrp_pkg::ST_ACCESS_ERR;
            res.error_code = in_byte;
            res.end_of_run = 1'b1;
         end
         dgrp_pkg::PH_TAG: begin
            res.tag        = in_byte;
            res.end_of_run = 1'b1;
            if (in_byte == dgrp_pkg::TAG_NULL) begin
               res_valid  = 1'b1;
               res.status = dgrp_pkg::ST_NULL;
            end else if (in_byte != dgrp_pkg::TAG_LU && in_byte != dgrp_pkg::TAG_DLU
                         && in_byte != dgrp_pkg::TAG_VISIBLE
                         && in_byte != dgrp_pkg::TAG_OCTET) begin
               res_valid  = 1'b1;
               res.status = dgrp_pkg::ST_UNSUPPORTED;
            end
         end
         dgrp_pkg::PH_STRING: begin
            res_valid      = 1'b1;
            res.status     = dgrp_pkg::ST_STRING_BYTE;
            res.tag        = held_tag_ff;
            res.data_byte  = in_byte;
            res.end_of_run = (bytes_dec == 8'd0);
         end
         dgrp_pkg::PH_CLOCK: begin
            if (index_inc >= CLOCK_LAST) begin
               res_valid      = 1'b1;
               res.status     = dgrp_pkg::ST_CLOCK;
               res.tag        = held_tag_ff;
               res.year       = {clock_hold_in[0], clock_hold_in[1]};
               res.month      = clock_hold_in[2];
               res.day        = clock_hold_in[3];
               res.hour       = clock_hold_in[5];
               res.minute     = clock_hold_in[6];
               res.second     = clock_hold_in[7];
               res.end_of_run = 1'b1;
            end
         end
         dgrp_pkg::PH_NUMBER: begin
            if (bytes_dec == 8'd0) begin
               res_valid        = 1'b1;
               res.status       = dgrp_pkg::ST_NUMBER;
               res.tag          = held_tag_ff;
               res.number_value = acc_in;
               res.end_of_run   = 1'b1;
            end
         end
         default: ;
      endcase
      // Frame end overrides any partial result
      if (frame_end) begin
         if (phase_step == dgrp_pkg::PH_SEARCH) begin
            res            = '0;
            res_valid      = 1'b1;
            res.status     = dgrp_pkg::ST_NO_RESPONSE;
            res.end_of_run = 1'b1;
         end else if (phase_step != dgrp_pkg::PH_DONE) begin
            res            = '0;
            res_valid      = 1'b1;
            res.status     = dgrp_pkg::ST_TRUNCATED;
            res.tag        = held_tag_in;
            res.end_of_run = 1'b1;
         end
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset || (step && frame_end)) begin
         phase_ff      <= dgrp_pkg::PH_SEARCH;
         held_tag_ff   <= '0;
         bytes_left_ff <= '0;
         byte_index_ff <= '0;
         acc_ff        <= '0;
      end else if (step) begin
         phase_ff      <= phase_in;
         held_tag_ff   <= held_tag_in;
         bytes_left_ff <= bytes_left_in;
         byte_index_ff <= byte_index_in;
         acc_ff        <= acc_in;
      end
   end

   // Clock octet hold (always fully written before it is read)
   always_ff @(posedge clock) begin
      if (step) begin
         clock_hold_ff <= clock_hold_in;
      end
   end

   // Only a string byte may leave a decode open
   a_open_only_string: assert property (@(posedge clock) disable iff (reset)
      (res_valid && !res.end_of_run) |-> (res.status == dgrp_pkg::ST_STRING_BYTE))
      else $error("non-final result that is not a string byte");

   // A finished decode stays silent until frame end
   a_done_silent: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == dgrp_pkg::PH_DONE && !frame_end) |-> !res_valid)
      else $error("result after decode finished");

   // Frame end always gives back the search phase
   a_fe_search: assert property (@(posedge clock) disable iff (reset)
      (step && frame_end) |=> (phase_ff == dgrp_pkg::PH_SEARCH))
      else $error("parser not back in search after frame end");

endmodule

FILE: hw/rtl/dlms_get_response_value_parser_top.sv
// Top level of the DLMS GET-Response value parser: input register, parser
// stage and result register. Depends on dgrp_pkg, dgrp_matcher, dgrp_decoder.

// The parser takes one frame byte per clock cycle and gives at most one result
// item per byte. A byte is captured in the input register and decoded by the
// parser stage into the result register, from which its result is offered;
// bytes may follow each other in every cycle, and the rate is set only by the
// result side: while a result waits under rsp_stall, one more byte is held in
// the input register and then req_stall rises. req_frame_end marks the last
// byte of a frame and sends the parser back to the header search; a frame that
// ends before a header match reports no response, and one that ends mid-decode
// reports truncated. CLOCK_OCTETS (8 to 12) is the octet string length that is
// read as a clock.
module dlms_get_response_value_parser_top #(
   parameter int CLOCK_OCTETS = dgrp_pkg::CLOCK_OCTETS
) (
   input  logic        clock,
   input  logic        reset,
   // byte input
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_in_byte,
   input  logic        req_frame_end,
   // result output
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic [7:0]  rsp_error_code,
   output logic [7:0]  rsp_tag,
   output logic [31:0] rsp_number_value,
   output logic [7:0]  rsp_data_byte,
   output logic [15:0] rsp_year,
   output logic [7:0]  rsp_month,
   output logic [7:0]  rsp_day,
   output logic [7:0]  rsp_hour,
   output logic [7:0]  rsp_minute,
   output logic [7:0]  rsp_second,
   output logic        rsp_end_of_run
);

   logic              in_valid_ff;
   logic [7:0]        in_byte_ff;
   logic              in_fe_ff;
   logic              go;
   logic              step;
   logic              searching;
   logic              res_valid;
   dgrp_pkg::match_type match;
   dgrp_pkg::rsp_type   res;
   logic              rsp_valid_ff, rsp_valid_in;
   dgrp_pkg::rsp_type   rsp_ff;

   // Parser stage moves when the result register can take its output
   assign go        = !(rsp_valid_ff && rsp_stall);
   assign step      = in_valid_ff && go;
   assign req_stall = in_valid_ff && !go;

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_byte_ff <= req_in_byte;
         in_fe_ff   <= req_frame_end;
      end
   end

   dgrp_matcher u_matcher (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .clear     (in_fe_ff),
      .searching (searching),
      .in_byte   (in_byte_ff),
      .match     (match)
   );

   dgrp_decoder #(
      .CLOCK_OCTETS (CLOCK_OCTETS)
   ) u_decoder (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .in_byte   (in_byte_ff),
      .frame_end (in_fe_ff),
      .match     (match),
      .searching (searching),
      .res_valid (res_valid),
      .res       (res)
   );

   // Result register
   assign rsp_valid_in = step && res_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (go) begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_valid_in) begin
         rsp_ff <= res;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_ff.status;
   assign rsp_error_code   = rsp_ff.error_code;
   assign rsp_tag          = rsp_ff.tag;
   assign rsp_number_value = rsp_ff.number_value;
   assign rsp_data_byte    = rsp_ff.data_byte;
   assign rsp_year         = rsp_ff.year;
   assign rsp_month        = rsp_ff.month;
   assign rsp_day          = rsp_ff.day;
   assign rsp_hour         = rsp_ff.hour;
   assign rsp_minute       = rsp_ff.minute;
   assign rsp_second       = rsp_ff.second;
   assign rsp_end_of_run   = rsp_ff.end_of_run;

endmodule

FILE: tb/sv/dlms_get_response_value_parser_top_tb.sv
// Self-checking testbench for dlms_get_response_value_parser_top: frames of
// bytes go in, decoded results are checked against an in-bench decoder model.
// Depends on dgrp_pkg and the parser RTL.
module dlms_get_response_value_parser_top_tb;

   // one byte of a frame as queued for the driver
   typedef struct packed {
      logic [7:0] value;
      logic       last;
   } frame_octet_type;

   localparam int RANDOM_BYTES = 650;
   localparam int HOLD_AT      = 300;
   localparam int HOLD_LEN     = 150;
   localparam int QUIET_FROM   = 600;
   localparam int QUIET_TO     = 800;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_in_byte = 8'h00;
   logic        req_frame_end = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [2:0]  rsp_status;
   logic [7:0]  rsp_error_code;
   logic [7:0]  rsp_tag;
   logic [31:0] rsp_number_value;
   logic [7:0]  rsp_data_byte;
   logic [15:0] rsp_year;
   logic [7:0]  rsp_month;
   logic [7:0]  rsp_day;
   logic [7:0]  rsp_hour;
   logic [7:0]  rsp_minute;
   logic [7:0]  rsp_second;
   logic        rsp_end_of_run;

   dlms_get_response_value_parser_top u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_in_byte      (req_in_byte),
      .req_frame_end    (req_frame_end),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_error_code   (rsp_error_code),
      .rsp_tag          (rsp_tag),
      .rsp_number_value (rsp_number_value),
      .rsp_data_byte    (rsp_data_byte),
      .rsp_year         (rsp_year),
      .rsp_month        (rsp_month),
      .rsp_day          (rsp_day),
      .rsp_hour         (rsp_hour),
      .rsp_minute       (rsp_minute),
      .rsp_second       (rsp_second),
      .rsp_end_of_run   (rsp_end_of_run)
   );

   // stimulus and scoreboard storage
   frame_octet_type     pending_bytes[$];
   logic [7:0]          frame_buf[$];
   dgrp_pkg::rsp_type   expected_results[$];
   int                  errors = 0;
   int                  frames_built = 0;
   int                  bytes_taken = 0;
   int                  results_checked = 0;
   int                  status_seen[8];
   int                  tick = 0;
   logic                byte_taken = 1'b0;

   // decoder model state
   logic [7:0]          win[4];
   logic [2:0]          win_fill;
   dgrp_pkg::phase_type ph;
   logic [7:0]          held_tag;
   logic [7:0]          left;
   logic [3:0]          idx;
   logic [31:0]         acc;
   logic [7:0]          clk_hold[8];

   initial begin
      forever #2 clock = ~clock;
   end

   // back to header search, all model state cleared
   function automatic void clear_decoder();
      for (int i = 0; i < 4; i++) win[i] = 8'h00;
      for (int i = 0; i < 8; i++) clk_hold[i] = 8'h00;
      win_fill = 3'd0;
      ph       = dgrp_pkg::PH_SEARCH;
      held_tag = 8'h00;
      left     = 8'h00;
      idx      = 4'd0;
      acc      = 32'h0;
   endfunction

   // decode one frame byte; returns 1 when it yields a result
   function automatic bit decode_byte(input logic [7:0] b, input logic fe,
                                      output dgrp_pkg::rsp_type r);
      bit got;
      got = 1'b0;
      r   = '0;
      case (ph)
         dgrp_pkg::PH_SEARCH: begin
            win[0] = win[1];
            win[1] = win[2];
            win[2] = win[3];
            win[3] = b;
            if (win_fill < 3'd4) win_fill = win_fill + 3'd1;
            if (win_fill == 3'd4 && win[0] == dgrp_pkg::GET_RSP_TAG
                && win[1] == dgrp_pkg::GET_RSP_NORMAL) begin
               if (win[3] == dgrp_pkg::RESULT_DATA) ph = dgrp_pkg::PH_TAG;
               else if (win[3] == dgrp_pkg::RESULT_ERROR) ph = dgrp_pkg::PH_ERRCODE;
            end
         end
         dgrp_pkg::PH_ERRCODE: begin
            r.status     = dgrp_pkg::ST_ACCESS_ERR;
            r.error_code = b;
            r.end_of_run = 1'b1;
            got = 1'b1;
            ph  = dgrp_pkg::PH_DONE;
         end
         dgrp_pkg::PH_TAG: begin
            held_tag = b;
            acc      = 32'h0;
            if (b == dgrp_pkg::TAG_NULL) begin
               r.status = dgrp_pkg::ST_NULL;
               r.tag    = b;
               r.end_of_run = 1'b1;
               got = 1'b1;
               ph  = dgrp_pkg::PH_DONE;
            end else if (b == dgrp_pkg::TAG_LU) begin
               left = 8'd2;
               ph   = dgrp_pkg::PH_NUMBER;
            end else if (b == dgrp_pkg::TAG_DLU) begin
               left = 8'd4;
               ph   = dgrp_pkg::PH_NUMBER;
            end else if (b == dgrp_pkg::TAG_VISIBLE) begin
               ph = dgrp_pkg::PH_VLEN;
            end else if (b == dgrp_pkg::TAG_OCTET) begin
               ph = dgrp_pkg::PH_OLEN;
            end else begin
               r.status = dgrp_pkg::ST_UNSUPPORTED;
               r.tag    = b;
               r.end_of_run = 1'b1;
               got = 1'b1;
               ph  = dgrp_pkg::PH_DONE;
            end
         end
         dgrp_pkg::PH_VLEN, dgrp_pkg::PH_OLEN: begin
            if (ph == dgrp_pkg::PH_OLEN && b == 8'(dgrp_pkg::CLOCK_OCTETS)) begin
               idx = 4'd0;
               ph  = dgrp_pkg::PH_CLOCK;
            end else if (b == 8'h00) begin
               ph = dgrp_pkg::PH_DONE;
            end else begin
               left = b;
               ph   = dgrp_pkg::PH_STRING;
            end
         end
         dgrp_pkg::PH_STRING: begin
            r.status    = dgrp_pkg::ST_STRING_BYTE;
            r.tag       = held_tag;
            r.data_byte = b;
            got  = 1'b1;
            left = left - 8'd1;
            if (left == 8'h00) begin
               r.end_of_run = 1'b1;
               ph = dgrp_pkg::PH_DONE;
            end
         end
         dgrp_pkg::PH_CLOCK: begin
            if (idx < 4'd8) clk_hold[idx[2:0]] = b;
            idx = idx + 4'd1;
            if (idx >= 4'(dgrp_pkg::CLOCK_OCTETS)) begin
               r.status = dgrp_pkg::ST_CLOCK;
               r.tag    = held_tag;
               r.year   = {clk_hold[0], clk_hold[1]};
               r.month  = clk_hold[2];
               r.day    = clk_hold[3];
               r.hour   = clk_hold[5];
               r.minute = clk_hold[6];
               r.second = clk_hold[7];
               r.end_of_run = 1'b1;
               got = 1'b1;
               ph  = dgrp_pkg::PH_DONE;
            end
         end
         dgrp_pkg::PH_NUMBER: begin
            acc  = {acc[23:0], b};
            left = left - 8'd1;
            if (left == 8'h00) begin
               r.status       = dgrp_pkg::ST_NUMBER;
               r.tag          = held_tag;
               r.number_value = acc;
               r.end_of_run   = 1'b1;
               got = 1'b1;
               ph  = dgrp_pkg::PH_DONE;
            end
         end
         default: ;
      endcase

      // frame end overrides the byte's result unless the decode has finished
      if (fe) begin
         if (ph == dgrp_pkg::PH_SEARCH) begin
            r = '0;
            r.status     = dgrp_pkg::ST_NO_RESPONSE;
            r.end_of_run = 1'b1;
            got = 1'b1;
         end else if (ph != dgrp_pkg::PH_DONE) begin
            r = '0;
            r.status     = dgrp_pkg::ST_TRUNCATED;
            r.tag        = held_tag;
            r.end_of_run = 1'b1;
            got = 1'b1;
         end
         clear_decoder();
      end
      return got;
   endfunction

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] seen);
      if (want !== seen) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, seen);
         errors++;
      end
   endfunction

   // frame building helpers
   task automatic put(input logic [7:0] b);
      frame_buf.push_back(b);
   endtask

   task automatic put_header(input logic [7:0] invoke_id, input logic [7:0] result);
      put(dgrp_pkg::GET_RSP_TAG);
      put(dgrp_pkg::GET_RSP_NORMAL);
      put(invoke_id);
      put(result);
   endtask

   // move the frame into the driver queue, frame end on its last byte
   task automatic flush_frame();
      for (int i = 0; i < frame_buf.size(); i++)
         pending_bytes.push_back('{value: frame_buf[i], last: (i == frame_buf.size() - 1)});
      frame_buf.delete();
      frames_built++;
   endtask

   // string length: mostly short, a few long ones
   function automatic int pick_len();
      int roll;
      roll = $urandom_range(99);
      if (roll < 88) return $urandom_range(0, 6);
      if (roll < 97) return $urandom_range(7, 12);
      return $urandom_range(13, 255);
   endfunction

   // one random frame: mostly well-formed responses, some noise and cut frames
   task automatic build_random_frame();
      int         n;
      int         len;
      int         cut;
      logic [7:0] t;
      if ($urandom_range(99) < 8) begin
         n = $urandom_range(1, 6);
         repeat (n) put(8'($urandom_range(255)));
      end else begin
         n = $urandom_range(0, 3);
         repeat (n) put(($urandom_range(3) == 0) ? dgrp_pkg::GET_RSP_TAG
                                                 : 8'($urandom_range(255)));
         // header with a result byte that keeps the search going
         if ($urandom_range(99) < 15)
            put_header(8'($urandom_range(255)), 8'($urandom_range(2, 255)));
         if ($urandom_range(99) < 15) begin
            put_header(8'($urandom_range(255)), dgrp_pkg::RESULT_ERROR);
            put(8'($urandom_range(255)));
         end else begin
            put_header(8'($urandom_range(255)), dgrp_pkg::RESULT_DATA);
            case ($urandom_range(5))
               0: put(dgrp_pkg::TAG_NULL);
               1: begin
                  put(dgrp_pkg::TAG_LU);
                  repeat (2) put(8'($urandom_range(255)));
               end
               2: begin
                  put(dgrp_pkg::TAG_DLU);
                  repeat (4) put(8'($urandom_range(255)));
               end
               3: begin
                  put(dgrp_pkg::TAG_VISIBLE);
                  len = pick_len();
                  put(8'(len));
                  repeat (len) put(8'($urandom_range(255)));
               end
               4: begin
                  put(dgrp_pkg::TAG_OCTET);
                  len = ($urandom_range(99) < 45) ? dgrp_pkg::CLOCK_OCTETS : pick_len();
                  put(8'(len));
                  repeat (len) put(8'($urandom_range(255)));
               end
               default: begin
                  do t = 8'($urandom_range(255));
                  while (t == dgrp_pkg::TAG_NULL || t == dgrp_pkg::TAG_LU ||
                         t == dgrp_pkg::TAG_DLU || t == dgrp_pkg::TAG_VISIBLE ||
                         t == dgrp_pkg::TAG_OCTET);
                  put(t);
               end
            endcase
         end
         n = $urandom_range(0, 2);
         repeat (n) put(8'($urandom_range(255)));
      end
      // cut the frame short at a random byte
      if ($urandom_range(99) < 15) begin
         cut = $urandom_range(1, frame_buf.size());
         while (frame_buf.size() > cut) void'(frame_buf.pop_back());
      end
      flush_frame();
   endtask

   function automatic bit take_break();
      if (tick >= QUIET_FROM && tick < QUIET_TO) return 1'b0;
      return $urandom_range(99) < 17;
   endfunction

   // byte driver: holds an item until it is taken
   always @(negedge clock) begin : drive_bytes
      frame_octet_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || byte_taken) begin
         if (pending_bytes.size() != 0 && !take_break()) begin
            nxt = pending_bytes.pop_front();
            req_valid     <= 1'b1;
            req_in_byte   <= nxt.value;
            req_frame_end <= nxt.last;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // result receiver: random stalls plus one long hold-off
   always @(negedge clock) begin : drive_stall
      int rx_cycles;
      int hold_left;
      if (reset) begin
         rx_cycles = 0;
         hold_left = 0;
         rsp_stall <= 1'b0;
      end else begin
         rx_cycles++;
         if (rx_cycles == HOLD_AT) hold_left = HOLD_LEN;
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= take_break();
         end
      end
   end

   // monitor: check accepted results, predict from accepted bytes
   always @(posedge clock) begin : watch
      dgrp_pkg::rsp_type want;
      dgrp_pkg::rsp_type pred;
      if (reset) begin
         byte_taken <= 1'b0;
      end else begin
         tick <= tick + 1;
         if (rsp_valid && !rsp_stall) begin
            status_seen[rsp_status]++;
            if (expected_results.size() == 0) begin
               $error("unexpected result: status %0d tag 0x%0h", rsp_status, rsp_tag);
               errors++;
            end else begin
               want = expected_results.pop_front();
               results_checked++;
               check_field("status", 32'(want.status), 32'(rsp_status));
               check_field("error_code", 32'(want.error_code), 32'(rsp_error_code));
               check_field("tag", 32'(want.tag), 32'(rsp_tag));
               check_field("number_value", want.number_value, rsp_number_value);
               check_field("data_byte", 32'(want.data_byte), 32'(rsp_data_byte));
               check_field("year", 32'(want.year), 32'(rsp_year));
               check_field("month", 32'(want.month), 32'(rsp_month));
               check_field("day", 32'(want.day), 32'(rsp_day));
               check_field("hour", 32'(want.hour), 32'(rsp_hour));
               check_field("minute", 32'(want.minute), 32'(rsp_minute));
               check_field("second", 32'(want.second), 32'(rsp_second));
               check_field("end_of_run", 32'(want.end_of_run), 32'(rsp_end_of_run));
            end
         end
         byte_taken <= req_valid && !req_stall;
         if (req_valid && !req_stall) begin
            bytes_taken++;
            if (decode_byte(req_in_byte, req_frame_end, pred)) expected_results.push_back(pred);
         end
      end
   end

   // stimulus, reset and end of run
   initial begin : run
      int directed_bytes;
      clear_decoder();
      for (int i = 0; i < 8; i++) status_seen[i] = 0;

      // frame end while still searching
      put(8'hFF);
      flush_frame();
      // unknown result byte, then null; bytes after the decode are ignored
      put_header(8'h00, 8'h07);
      put_header(8'hFF, dgrp_pkg::RESULT_DATA);
      put(dgrp_pkg::TAG_NULL);
      put(8'hAB);
      flush_frame();
      // access error with the largest code
      put_header(8'h5A, dgrp_pkg::RESULT_ERROR);
      put(8'hFF);
      flush_frame();
      // match completed on the frame end byte
      put_header(8'h00, dgrp_pkg::RESULT_DATA);
      flush_frame();
      // string cut mid-way: the partial byte is dropped
      put_header(8'h01, dgrp_pkg::RESULT_DATA);
      put(dgrp_pkg::TAG_VISIBLE);
      put(8'd3);
      put(8'h41);
      put(8'h42);
      flush_frame();
      // empty octet string, then frame end after the decode
      put_header(8'h02, dgrp_pkg::RESULT_DATA);
      put(dgrp_pkg::TAG_OCTET);
      put(8'h00);
      put(8'h00);
      flush_frame();

      directed_bytes = pending_bytes.size();
      while (pending_bytes.size() < directed_bytes + RANDOM_BYTES) build_random_frame();

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // all bytes offered and taken, then drain the results
      while (pending_bytes.size() != 0 || req_valid) @(posedge clock);
      while (expected_results.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      $display("%0d bytes in %0d frames, %0d results checked: number %0d, string %0d,",
               bytes_taken, frames_built, results_checked,
               status_seen[dgrp_pkg::ST_NUMBER], status_seen[dgrp_pkg::ST_STRING_BYTE]);
      $display("clock %0d, null %0d, error %0d, unsupported %0d, none %0d, cut %0d",
               status_seen[dgrp_pkg::ST_CLOCK], status_seen[dgrp_pkg::ST_NULL],
               status_seen[dgrp_pkg::ST_ACCESS_ERR], status_seen[dgrp_pkg::ST_UNSUPPORTED],
               status_seen[dgrp_pkg::ST_NO_RESPONSE], status_seen[dgrp_pkg::ST_TRUNCATED]);
      if (errors == 0 && expected_results.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   // watchdog
   initial begin
      #200000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
